/* src/wpm_pkg.sv */
`timescale 1ns / 1ps

package wpm_pkg;

    // Word and pattern limits.
    localparam int WORD_MAX = 32;
    localparam int PAT_MAX  = 32;
    localparam int CNT_W    = $clog2(WORD_MAX + 1);
    localparam int LEN_W    = 6;
    localparam int DEL_W    = 5;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_ADDR_W-1:0] REG_PAT_LO     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PAT_MID_LO = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PAT_MID_HI = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PAT_HI     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PAT_LEN    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE       = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_DEL_COUNT  = 3'd6;

    localparam logic MODE_SUBSTRING = 1'b0;
    localparam logic MODE_SIMILAR   = 1'b1;

    // Delimiter characters.
    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_SP  = 8'h20;

    // Decoded configuration handed to the cell row and the word logic.
    typedef struct packed {
        logic [PAT_MAX-1:0][7:0] pat_chars;
        logic [LEN_W-1:0]        plen;
        logic                    mode;
        logic [DEL_W-1:0]        del_count;
        logic [PAT_MAX-1:0]      active;
        logic [PAT_MAX-1:0]      last;
        logic [PAT_MAX-1:0]      at_len;
    } t_cfg;

    // Per-beat control shared by all cells.
    typedef struct packed {
        logic step;
        logic clear;
    } t_cell_ctl;

endpackage

/* src/word_pattern_matcher_core.sv */
`timescale 1ns / 1ps
// Word pattern matcher.
// The slave channel takes one text byte per beat (tdata[7:0] = text_byte).
// Space, tab, CR, LF and NUL end a word; LF and NUL also end the line.
// When a non-empty word ends, one beat leaves on the master channel with
// tdata = {word_overflow, word_length[5:0], word_matched} and tlast set when
// the line ended. Bytes that do not end a word, and delimiters after an
// empty word, give no beat.
// Throughput is one byte per cycle unless a stalled result holds tready low:
// a row of 32 cells updates the shift-and vector and the one-hot subsequence
// pointer in the cycle the byte arrives. The result beat leaves from the
// output register in the cycle after the delimiter beat.
// When the receiver stalls, the result stays in the output register and the
// slave side holds tready low until that result has been taken.
// The configuration channel writes one register per beat and is always
// ready; write it only while no text is in flight.
// Reset (synchronous, active low) loads the default configuration, clears
// the word state and empties the output register.
module word_pattern_matcher_core
    import wpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Text stream. tdata: [7:0] text_byte.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,
    // Result stream. tdata: [0] word_matched, [6:1] word_length,
    // [7] word_overflow. tlast: line_ended.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,
    output logic                  m_axis_tlast
);

    t_cfg               cfg;
    t_cell_ctl          ctl;
    logic [PAT_MAX-1:0] hit_vec;
    logic [PAT_MAX-1:0] adv_vec;
    logic [PAT_MAX-1:0] last_hit_vec;
    logic [PAT_MAX-1:0] at_len_vec;

    logic [CNT_W-1:0]   r_chars;
    logic               r_too_long;
    logic               r_found;
    logic               r_ptr_end;

    logic               r_out_valid;
    logic               r_out_match;
    logic [LEN_W-1:0]   r_out_len;
    logic               r_out_ovf;
    logic               r_out_last;

    logic               accept;
    logic               line_end;
    logic               delim;
    logic               full;
    logic               emit;
    logic               at_plen;
    logic [LEN_W:0]     plen_plus_del;
    logic               matched;

    wpm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Beat classification.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign line_end      = (s_axis_tdata == CHAR_LF) || (s_axis_tdata == CHAR_NUL);
    assign delim         = line_end || (s_axis_tdata == CHAR_SP) ||
                           (s_axis_tdata == CHAR_TAB) || (s_axis_tdata == CHAR_CR);
    assign full          = (r_chars >= CNT_W'(WORD_MAX));
    assign emit          = accept && delim && ((r_chars != '0) || r_too_long);

    assign ctl.step  = accept && !delim && !full;
    assign ctl.clear = accept && delim;

    // Row of matching cells.
    for (genvar g = 0; g < PAT_MAX; g++) begin : g_cell
        wpm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_char     (s_axis_tdata),
            .i_pat_char (cfg.pat_chars[g]),
            .i_active   (cfg.active[g]),
            .i_last     (cfg.last[g]),
            .i_at_len   (cfg.at_len[g]),
            .i_home     ((g == 0) ? 1'b1 : 1'b0),
            .i_hit_left ((g == 0) ? 1'b1 : hit_vec[(g == 0) ? 0 : g-1]),
            .i_adv_left ((g == 0) ? 1'b0 : adv_vec[(g == 0) ? 0 : g-1]),
            .o_hit      (hit_vec[g]),
            .o_adv      (adv_vec[g]),
            .o_last_hit (last_hit_vec[g]),
            .o_at_len   (at_len_vec[g])
        );
    end

    // Word state: length count, overflow flag, substring flag, pointer end slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctl.clear) begin
            r_chars    <= '0;
            r_too_long <= 1'b0;
            r_found    <= 1'b0;
            r_ptr_end  <= 1'b0;
        end else if (ctl.step) begin
            r_chars <= r_chars + CNT_W'(1);
            if (|last_hit_vec) begin
                r_found <= 1'b1;
            end
            if (adv_vec[PAT_MAX-1]) begin
                r_ptr_end <= 1'b1;
            end
        end else if (accept && !delim) begin
            r_too_long <= 1'b1;
        end
    end

    // Word verdict at the delimiter.
    assign at_plen       = (|at_len_vec) || (r_ptr_end && (cfg.plen == LEN_W'(PAT_MAX)));
    assign plen_plus_del = {1'b0, cfg.plen} + (LEN_W + 1)'(cfg.del_count);

    always_comb begin
        matched = 1'b0;
        if (!r_too_long) begin
            if (cfg.mode == MODE_SUBSTRING) begin
                matched = r_found;
            end else begin
                matched = at_plen &&
                          (((LEN_W + 1)'(r_chars) == (LEN_W + 1)'(cfg.plen)) ||
                           ((LEN_W + 1)'(r_chars) == plen_plus_del));
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_match <= matched;
            r_out_len   <= LEN_W'(r_chars);
            r_out_ovf   <= r_too_long;
            r_out_last  <= line_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_ovf, r_out_len, r_out_match};
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // A stalled result beat stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result beat changed");
    // The character count never passes the word limit.
    a_chars_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chars <= CNT_W'(WORD_MAX))
        else $error("word length count passed the limit");
    // An overlong word has the full count.
    a_too_long_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_too_long |-> (r_chars == CNT_W'(WORD_MAX)))
        else $error("overflow flag without a full word");
    // An overflowed word never reports a match.
    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out_ovf) |-> !r_out_match)
        else $error("overflowed word reported a match");
    // A result is only produced for a delimiter beat after a non-empty word.
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (m_axis_tvalid && ((r_out_len != '0) || r_out_ovf)))
        else $error("result beat for an empty word");
`endif

endmodule

/* src/wpm_cfg_regs.sv */
`timescale 1ns / 1ps

module wpm_cfg_regs
    import wpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic [3:0][CFG_DATA_W-1:0] r_pat;
    logic [LEN_W-1:0]           r_plen_raw;
    logic                       r_mode;
    logic [DEL_W-1:0]           r_del;
    logic [LEN_W-1:0]           plen_eff;

    assign o_cfg_ready = 1'b1;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat      <= '0;
            r_plen_raw <= LEN_W'(1);
            r_mode     <= MODE_SUBSTRING;
            r_del      <= DEL_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_PAT_LO:     r_pat[0]   <= i_cfg_data;
                REG_PAT_MID_LO: r_pat[1]   <= i_cfg_data;
                REG_PAT_MID_HI: r_pat[2]   <= i_cfg_data;
                REG_PAT_HI:     r_pat[3]   <= i_cfg_data;
                REG_PAT_LEN:    r_plen_raw <= i_cfg_data[LEN_W-1:0];
                REG_MODE:       r_mode     <= i_cfg_data[0];
                REG_DEL_COUNT:  r_del      <= i_cfg_data[DEL_W-1:0];
                default: ;
            endcase
        end
    end

    // A length of zero acts as one, anything above the pattern size as full size.
    always_comb begin
        if (r_plen_raw == '0) begin
            plen_eff = LEN_W'(1);
        end else if (r_plen_raw > LEN_W'(PAT_MAX)) begin
            plen_eff = LEN_W'(PAT_MAX);
        end else begin
            plen_eff = r_plen_raw;
        end
    end

    // Per-position decodes of the pattern length.
    always_comb begin
        o_cfg.pat_chars = r_pat;
        o_cfg.plen      = plen_eff;
        o_cfg.mode      = r_mode;
        o_cfg.del_count = r_del;
        for (int i = 0; i < PAT_MAX; i++) begin
            o_cfg.active[i] = LEN_W'(i) < plen_eff;
            o_cfg.last[i]   = (LEN_W'(i + 1) == plen_eff);
            o_cfg.at_len[i] = (LEN_W'(i) == plen_eff);
        end
    end

endmodule

/* src/wpm_cell.sv */
`timescale 1ns / 1ps

module wpm_cell
    import wpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  logic [7:0] i_char,
    input  logic [7:0] i_pat_char,
    input  logic       i_active,
    input  logic       i_last,
    input  logic       i_at_len,
    input  logic       i_home,
    input  logic       i_hit_left,
    input  logic       i_adv_left,
    output logic       o_hit,
    output logic       o_adv,
    output logic       o_last_hit,
    output logic       o_at_len
);

    logic r_hit;
    logic r_ptr;
    logic match;
    logic n_hit;
    logic n_ptr;

    // This cell holds one bit of the shift-and vector and one slot of the
    // one-hot subsequence pointer.
    assign match      = i_active && (i_char == i_pat_char);
    assign n_hit      = i_hit_left && match;
    assign o_adv      = r_ptr && match;
    assign n_ptr      = (r_ptr && !o_adv) || i_adv_left;
    assign o_hit      = r_hit;
    assign o_last_hit = n_hit && i_last;
    assign o_at_len   = r_ptr && i_at_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_hit <= 1'b0;
            r_ptr <= i_home;
        end else if (i_ctl.step) begin
            r_hit <= n_hit;
            r_ptr <= n_ptr;
        end
    end

endmodule

/* tb/word_pattern_matcher_core_tb.sv */
`timescale 1ns / 1ps

module word_pattern_matcher_core_tb;
    import wpm_pkg::*;

    localparam int NUM_PHASES      = 9;
    localparam int BYTES_PER_PHASE = 185;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int MAX_PRINTED     = 50;

    // One finished word as it leaves on the result stream.
    typedef struct packed {
        logic             matched;
        logic [LEN_W-1:0] length;
        logic             overflow;
        logic             line_end;
    } t_word_result;

    typedef enum logic {ROW_CONFIG, ROW_TEXT} t_row_kind;

    // One row of the directed stimulus table.
    typedef struct {
        t_row_kind             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] value;
        logic [7:0]            ch;
        int                    reps;
        bit                    typed;
        t_word_result          want;
    } t_stim_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;
    logic                  m_axis_tlast;

    word_pattern_matcher_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // Matcher copy: configuration as written and the per-word state.
    logic [CFG_DATA_W-1:0] pat_reg [4] = '{default: '0};
    logic [LEN_W-1:0]      plen_reg    = 6'd1;
    logic                  mode_reg    = MODE_SUBSTRING;
    logic [DEL_W-1:0]      del_reg     = 5'd1;
    logic [PAT_MAX-1:0]    shift_vec   = '0;
    logic                  substr_seen = 1'b0;
    logic [5:0]            subseq_ptr  = '0;
    logic [5:0]            word_chars  = '0;
    logic                  word_long   = 1'b0;

    t_word_result expected_words[$];
    t_word_result got_word;
    t_word_result want_word;
    t_word_result none_typed = '0;
    t_stim_row    stim_rows[$];

    int n_errors      = 0;
    int text_beats    = 0;
    int result_beats  = 0;
    int match_beats   = 0;
    int overflow_beats = 0;
    int src_idle_pct  = 16;
    int sink_idle_pct = 62;
    int idle_cycles   = 0;

    function automatic logic [7:0] pattern_char(input int i);
        return pat_reg[(i >> 3) & 3][(i & 7) * 8 +: 8];
    endfunction

    // Out-of-range lengths are clamped the same way the block does.
    function automatic int active_length();
        if (plen_reg == 0) return 1;
        if (plen_reg > PAT_MAX) return PAT_MAX;
        return int'(plen_reg);
    endfunction

    function automatic logic [7:0] alpha_char();
        int pick;
        pick = $urandom_range(3);
        return 8'h61 + pick[7:0];
    endfunction

    function automatic logic [63:0] alpha_word();
        logic [63:0] w;
        int i;
        for (i = 0; i < 8; i++) w[i * 8 +: 8] = alpha_char();
        return w;
    endfunction

    function automatic t_word_result res_of(input bit m, input int len, input bit ovf,
                                            input bit le);
        t_word_result r;
        r.matched  = m;
        r.length   = len[LEN_W-1:0];
        r.overflow = ovf;
        r.line_end = le;
        return r;
    endfunction

    // Advance the word state by one text byte; a finished word yields a result.
    task automatic advance_matcher(input logic [7:0] c, output bit produced,
                                   output t_word_result res);
        int plen;
        int i;
        logic [PAT_MAX-1:0] hit_mask;
        bit line_end;
        bit is_delim;
        plen = active_length();
        line_end = (c == CHAR_LF) || (c == CHAR_NUL);
        is_delim = line_end || (c == CHAR_SP) || (c == CHAR_TAB) || (c == CHAR_CR);
        produced = 1'b0;
        res = '0;
        if (!is_delim) begin
            if (word_chars >= WORD_MAX) begin
                word_long = 1'b1;
            end else begin
                hit_mask = '0;
                for (i = 0; i < plen; i++)
                    if (pattern_char(i) == c) hit_mask[i] = 1'b1;
                shift_vec = ((shift_vec << 1) | 32'd1) & hit_mask;
                if (shift_vec[plen-1]) substr_seen = 1'b1;
                if (subseq_ptr < plen && pattern_char(int'(subseq_ptr)) == c)
                    subseq_ptr = subseq_ptr + 6'd1;
                word_chars = word_chars + 6'd1;
            end
        end else begin
            if (word_chars != 0 || word_long) begin
                produced = 1'b1;
                if (word_long)
                    res.matched = 1'b0;
                else if (mode_reg == MODE_SUBSTRING)
                    res.matched = substr_seen;
                else
                    res.matched = (int'(subseq_ptr) == plen) &&
                                  (int'(word_chars) == plen ||
                                   int'(word_chars) == plen + int'(del_reg));
                res.length   = word_chars;
                res.overflow = word_long;
                res.line_end = line_end;
            end
            shift_vec   = '0;
            substr_seen = 1'b0;
            subseq_ptr  = '0;
            word_chars  = '0;
            word_long   = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        if (n_errors < MAX_PRINTED)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got_v,
                     want_v);
        n_errors++;
    endtask

    // Send one text beat; the matcher copy runs when the beat is taken.
    task automatic send_text(input logic [7:0] c, input bit typed, input t_word_result want);
        bit produced;
        t_word_result res;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        text_beats++;
        advance_matcher(c, produced, res);
        if (produced || typed) expected_words.push_back(typed ? want : res);
    endtask

    // Hold the text stream until every result is in, then let the block settle.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (addr)
            REG_PAT_LO:     pat_reg[0] = value;
            REG_PAT_MID_LO: pat_reg[1] = value;
            REG_PAT_MID_HI: pat_reg[2] = value;
            REG_PAT_HI:     pat_reg[3] = value;
            REG_PAT_LEN:    plen_reg = value[LEN_W-1:0];
            REG_MODE:       mode_reg = value[0];
            REG_DEL_COUNT:  del_reg = value[DEL_W-1:0];
            default: ;
        endcase
    endtask

    function automatic void add_cfg(input logic [CFG_ADDR_W-1:0] addr,
                                    input logic [CFG_DATA_W-1:0] value);
        t_stim_row row;
        row = '{kind: ROW_CONFIG, addr: addr, value: value, ch: 8'h00, reps: 0,
                typed: 1'b0, want: '0};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_text(input logic [7:0] ch, input int reps, input bit typed,
                                     input t_word_result want);
        t_stim_row row;
        row = '{kind: ROW_TEXT, addr: '0, value: '0, ch: ch, reps: reps, typed: typed,
                want: want};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_word(input string s);
        int i;
        for (i = 0; i < s.len(); i++) add_text(s[i], 1, 1'b0, '0);
    endfunction

    // One random word and its delimiter. Most words are built around the
    // pattern so the match logic gets exercised; the rest are noise.
    task automatic send_random_word();
        logic [7:0] w[$];
        int kind;
        int plen;
        int n;
        int i;
        int pos;
        logic [7:0] delim;
        plen = active_length();
        kind = $urandom_range(99);
        if (kind < 30) begin
            // Pattern embedded in a word.
            n = $urandom_range(3);
            repeat (n) w.push_back(alpha_char());
            for (i = 0; i < plen; i++) w.push_back(pattern_char(i));
            n = $urandom_range(3);
            repeat (n) w.push_back(alpha_char());
        end else if (kind < 55) begin
            // Pattern with extra characters sprinkled in, mostly the deletion count.
            for (i = 0; i < plen; i++) w.push_back(pattern_char(i));
            n = ($urandom_range(3) == 0) ? $urandom_range(5) : int'(del_reg);
            repeat (n) begin
                pos = $urandom_range(w.size());
                w.insert(pos, alpha_char());
            end
            // Now and then a near miss with one character dropped.
            if ($urandom_range(3) == 0 && w.size() > 1)
                w.delete($urandom_range(w.size() - 1));
        end else if (kind < 80) begin
            n = $urandom_range(1, 8);
            repeat (n) w.push_back(alpha_char());
        end else if (kind < 92) begin
            // Raw bytes, which may hold delimiters of their own.
            n = $urandom_range(1, 6);
            repeat (n) w.push_back(8'($urandom_range(255)));
        end else begin
            // Around the word length limit.
            n = $urandom_range(WORD_MAX - 1, WORD_MAX + 8);
            repeat (n) w.push_back(alpha_char());
        end
        foreach (w[k]) send_text(w[k], 1'b0, none_typed);
        repeat ($urandom_range(3) == 0 ? 2 : 1) begin
            case ($urandom_range(4))
                0: delim = CHAR_SP;
                1: delim = CHAR_TAB;
                2: delim = CHAR_CR;
                3: delim = CHAR_LF;
                default: delim = CHAR_NUL;
            endcase
            send_text(delim, 1'b0, none_typed);
        end
    endtask

    // Result checker: every beat against the oldest expected word.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_word.matched  = m_axis_tdata[0];
            got_word.length   = m_axis_tdata[6:1];
            got_word.overflow = m_axis_tdata[7];
            got_word.line_end = m_axis_tlast;
            result_beats++;
            if (expected_words.size() == 0) begin
                report_mismatch("result beat with nothing expected, tdata",
                                int'(m_axis_tdata), 0);
            end else begin
                want_word = expected_words.pop_front();
                if (got_word.matched !== want_word.matched)
                    report_mismatch("word_matched", got_word.matched, want_word.matched);
                if (got_word.length !== want_word.length)
                    report_mismatch("word_length", got_word.length, want_word.length);
                if (got_word.overflow !== want_word.overflow)
                    report_mismatch("word_overflow", got_word.overflow, want_word.overflow);
                if (got_word.line_end !== want_word.line_end)
                    report_mismatch("line_ended", got_word.line_end, want_word.line_end);
                if (want_word.matched) match_beats++;
                if (want_word.overflow) overflow_beats++;
            end
        end
    end

    // Receiver stalls.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog: cycles in a row with no beat on any channel.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Timeout after %0d cycles without a beat", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_stim_row row;
        bit in_cfg;
        int phase;
        int phase_start;
        int plen_val;
        int del_val;
        bit wide_pattern;

        // Directed table. Reset pattern is all NUL, which can never match.
        add_word("a");
        add_text(CHAR_SP, 1, 1'b1, res_of(1'b0, 1, 1'b0, 1'b0));
        // A delimiter after an empty word gives nothing.
        add_text(CHAR_SP, 1, 1'b0, '0);
        // Overlong word of all-ones bytes, ended by a newline.
        add_text(8'hFF, WORD_MAX + 1, 1'b0, '0);
        add_text(CHAR_LF, 1, 1'b1, res_of(1'b0, WORD_MAX, 1'b1, 1'b1));
        add_text(8'h01, 1, 1'b0, '0);
        add_text(CHAR_NUL, 1, 1'b1, res_of(1'b0, 1, 1'b0, 1'b1));
        // Substring mode with pattern "ab".
        add_cfg(REG_PAT_LO, 64'h6261);
        add_cfg(REG_PAT_LEN, 64'd2);
        add_word("xaby");
        add_text(CHAR_TAB, 1, 1'b0, '0);
        add_word("ba");
        add_text(CHAR_CR, 1, 1'b0, '0);
        // Length zero acts as one; a space inside the pattern never matches.
        add_cfg(REG_PAT_LO, 64'h207A);
        add_cfg(REG_PAT_LEN, 64'd0);
        add_word("z");
        add_text(CHAR_SP, 1, 1'b0, '0);
        add_cfg(REG_PAT_LEN, 64'd2);
        add_word("z");
        add_text(CHAR_SP, 1, 1'b0, '0);
        // Similar mode, one extra character allowed.
        add_cfg(REG_PAT_LO, 64'h6261);
        add_cfg(REG_MODE, 64'(MODE_SIMILAR));
        add_cfg(REG_DEL_COUNT, 64'd1);
        add_word("axb");
        add_text(CHAR_SP, 1, 1'b0, '0);
        add_word("ab");
        add_text(CHAR_LF, 1, 1'b0, '0);
        add_word("aaxb");
        add_text(CHAR_SP, 1, 1'b0, '0);
        // Top deletion count and all-ones upper pattern words.
        add_cfg(REG_DEL_COUNT, 64'd31);
        add_cfg(REG_PAT_MID_LO, '1);
        add_cfg(REG_PAT_MID_HI, '1);
        add_cfg(REG_PAT_HI, '1);
        add_word("ab");
        add_text(CHAR_SP, 1, 1'b0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_cfg = 1'b0;
        foreach (stim_rows[r]) begin
            row = stim_rows[r];
            if (row.kind == ROW_CONFIG) begin
                if (!in_cfg) begin
                    wait_for_results();
                    in_cfg = 1'b1;
                end
                write_register(row.addr, row.value);
            end else begin
                if (in_cfg) begin
                    i_cfg_valid <= 1'b0;
                    in_cfg = 1'b0;
                end
                repeat (row.reps) send_text(row.ch, row.typed, row.want);
            end
        end

        // Random phases, each under its own setting.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase < 3) begin
                src_idle_pct  = 16;
                sink_idle_pct = 62;
            end else if (phase < 6) begin
                src_idle_pct  = 62;
                sink_idle_pct = 16;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            case (phase)
                0:       plen_val = 1;
                1:       plen_val = 32;
                2:       plen_val = 0;
                3:       plen_val = 63;
                default: plen_val = $urandom_range(2, 6);
            endcase
            case (phase)
                5:       del_val = 0;
                7:       del_val = 31;
                default: del_val = $urandom_range(0, 3);
            endcase
            wide_pattern = (phase == 4) || (phase == 8);

            wait_for_results();
            write_register(REG_PAT_LO, wide_pattern ? {$urandom, $urandom} : alpha_word());
            write_register(REG_PAT_MID_LO,
                           wide_pattern ? {$urandom, $urandom} : alpha_word());
            write_register(REG_PAT_MID_HI,
                           wide_pattern ? {$urandom, $urandom} : alpha_word());
            write_register(REG_PAT_HI, wide_pattern ? {$urandom, $urandom} : alpha_word());
            write_register(REG_PAT_LEN, 64'(plen_val));
            write_register(REG_MODE, phase[0] ? 64'(MODE_SIMILAR) : 64'(MODE_SUBSTRING));
            write_register(REG_DEL_COUNT, 64'(del_val));
            i_cfg_valid <= 1'b0;

            phase_start = text_beats;
            while (text_beats - phase_start < BYTES_PER_PHASE) send_random_word();
        end

        wait_for_results();
        $display("Sent %0d text bytes over %0d settings; checked %0d words", text_beats,
                 NUM_PHASES + 1, result_beats);
        $display("(%0d matches, %0d overlong), %0d mismatches", match_beats,
                 overflow_beats, n_errors);
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
src/wpm_pkg.sv
src/wpm_cfg_regs.sv
src/wpm_cell.sv
src/word_pattern_matcher_core.sv
tb/word_pattern_matcher_core_tb.sv
